@@ hw/rtl/fldr_pkg.sv @@
// Shared types and constants of the fault log with repeat folding.
`timescale 1ns / 1ps
package fldr_pkg;

   localparam int SRC_W    = 3;
   localparam int CODE_W   = 4;
   localparam int TIME_W   = 32;
   localparam int REP_W    = 16;
   localparam int TOTAL_W  = 32;
   localparam int SLOT_W   = 4;
   localparam int NUM_SOURCES = 5;
   localparam int ENTRY_W  = SRC_W + CODE_W + TIME_W + REP_W;

   localparam logic [SRC_W-1:0] SRC_LIMIT  = 3'd5;
   localparam logic [REP_W-1:0] REPEAT_MAX = 16'hFFFF;
   localparam logic [REP_W-1:0] REPEAT_ONE = 16'd1;

   localparam logic KIND_RECORD = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [SRC_W-1:0]  fault_source;
      logic [CODE_W-1:0] fault_code;
      logic [TIME_W-1:0] time_ms;
      logic [SLOT_W-1:0] read_slot;
   } req_type;

   typedef struct packed {
      logic [SRC_W-1:0]   out_source;
      logic [CODE_W-1:0]  out_code;
      logic [TIME_W-1:0]  out_time_ms;
      logic [REP_W-1:0]   repeat_count;
      logic [TOTAL_W-1:0] source_total;
      logic [SLOT_W-1:0]  recent_count;
      logic [SLOT_W-1:0]  slot_used;
   } rsp_type;

   typedef struct packed {
      logic [SRC_W-1:0]  source;
      logic [CODE_W-1:0] code;
      logic [TIME_W-1:0] time_ms;
      logic [REP_W-1:0]  repeat_count;
   } entry_type;

endpackage

@@ hw/rtl/fldr_mem.sv @@
// Synchronous memory with a registered read and per-entry valid bits, so that entries never written read as zero.
`timescale 1ns / 1ps
module fldr_mem #(
   parameter int DEPTH  = 12,
   parameter int WIDTH  = 55,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [WIDTH-1:0] rd_data_ff;
   logic             rd_vld_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_vld_ff <= vld_ff[rd_addr];
         end
      end
   end

   // An entry never written reads as its reset value of zero
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

@@ hw/rtl/fault_log_dedup_ring.sv @@
// Top level of the fault log: repeat folding, per-source counters and a ring of recent faults.
`timescale 1ns / 1ps
// Each beat on req_ either records a fault or reads one ring slot and one source
// counter, and gives exactly one beat on rsp_. A beat is taken into a single
// stage that issues the reads of the counter memory and the ring memory; in the
// next cycle the synchronous read data is there. Once the output register is
// free, a record is folded against the last fault and written back, and the
// result moves to the output register. Items pass one at a time: no new beat is
// taken until the stage has moved its item on, but the next beat may
// be taken while the previous result still waits on rsp_stall. After reset all
// counters, the last fault and every ring slot read as zero at once; no clearing
// pass is needed.
module fault_log_dedup_ring #(
   parameter int RING_DEPTH = 12
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  fldr_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output fldr_pkg::rsp_type rsp_data
);

   localparam int RING_AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FILL_W  = $clog2(RING_DEPTH + 1);
   localparam int EXT_W   = (RING_AW > fldr_pkg::SLOT_W) ? RING_AW : fldr_pkg::SLOT_W;
   localparam int FEXT_W  = (FILL_W > fldr_pkg::SLOT_W) ? FILL_W : fldr_pkg::SLOT_W;

   // Stage holding the accepted item while the memories are read
   logic              s1_valid_ff, s1_valid_in;
   fldr_pkg::req_type s1_req_ff;
   logic              s1_src_ok_ff;
   logic              s1_slot_ok_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   fldr_pkg::rsp_type rsp_ff, rsp_in;

   logic [fldr_pkg::SRC_W-1:0]  last_source_ff, last_source_in;
   logic [fldr_pkg::CODE_W-1:0] last_code_ff, last_code_in;
   logic [fldr_pkg::TIME_W-1:0] last_time_ff, last_time_in;
   logic [fldr_pkg::REP_W-1:0]  last_repeat_ff, last_repeat_in;
   logic [RING_AW-1:0]          head_ff, head_in;
   logic [FILL_W-1:0]           fill_ff, fill_in;

   logic                          accept;
   logic                          advance;
   logic                          src_ok;
   logic                          slot_ok;
   logic [EXT_W-1:0]              rd_slot_ext;
   logic [RING_AW-1:0]            ring_rd_addr;
   logic [fldr_pkg::ENTRY_W-1:0]  ring_rd_raw;
   fldr_pkg::entry_type           ring_rd_entry;
   fldr_pkg::entry_type           new_entry;
   logic [fldr_pkg::TOTAL_W-1:0]  cnt_rd;
   logic [fldr_pkg::TOTAL_W-1:0]  cnt_cur;
   logic [fldr_pkg::TOTAL_W-1:0]  cnt_next;
   logic                          is_record;
   logic                          match;
   logic                          cnt_wr_en;
   logic                          ring_wr_en;
   logic [EXT_W-1:0]              head_ext;
   logic [FEXT_W-1:0]             fill_ext;

   assign accept    = req_valid && !req_stall;
   assign req_stall = s1_valid_ff || reset;
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);

   assign src_ok      = req_data.fault_source < fldr_pkg::SRC_LIMIT;
   assign slot_ok     = 32'(req_data.read_slot) < 32'(RING_DEPTH);
   assign rd_slot_ext = EXT_W'(req_data.read_slot);
   assign ring_rd_addr = slot_ok ? rd_slot_ext[RING_AW-1:0] : '0;

   assign is_record = s1_req_ff.kind == fldr_pkg::KIND_RECORD;
   assign match     = (last_code_ff == s1_req_ff.fault_code) &&
                      (last_source_ff == s1_req_ff.fault_source);

   assign cnt_cur  = s1_src_ok_ff ? cnt_rd : '0;
   assign cnt_next = cnt_cur + 32'd1;

   assign cnt_wr_en  = advance && is_record && s1_src_ok_ff;
   assign ring_wr_en = advance && is_record;

   assign ring_rd_entry = fldr_pkg::entry_type'(ring_rd_raw);

   fldr_mem #(
      .DEPTH  (fldr_pkg::NUM_SOURCES),
      .WIDTH  (fldr_pkg::TOTAL_W),
      .ADDR_W (fldr_pkg::SRC_W)
   ) u_cnt_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept && src_ok),
      .rd_addr (req_data.fault_source),
      .rd_data (cnt_rd),
      .wr_en   (cnt_wr_en),
      .wr_addr (s1_req_ff.fault_source),
      .wr_data (cnt_next)
   );

   fldr_mem #(
      .DEPTH  (RING_DEPTH),
      .WIDTH  (fldr_pkg::ENTRY_W),
      .ADDR_W (RING_AW)
   ) u_ring_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (ring_rd_addr),
      .rd_data (ring_rd_raw),
      .wr_en   (ring_wr_en),
      .wr_addr (head_ff),
      .wr_data (new_entry)
   );

   // Fold the record into the last fault
   always_comb begin
      new_entry.source  = s1_req_ff.fault_source;
      new_entry.code    = s1_req_ff.fault_code;
      new_entry.time_ms = s1_req_ff.time_ms;
      if (match) begin
         new_entry.repeat_count = (last_repeat_ff == fldr_pkg::REPEAT_MAX) ?
                                  last_repeat_ff : last_repeat_ff + 16'd1;
      end else begin
         new_entry.repeat_count = fldr_pkg::REPEAT_ONE;
      end
   end

   always_comb begin
      s1_valid_in    = s1_valid_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      last_source_in = last_source_ff;
      last_code_in   = last_code_ff;
      last_time_in   = last_time_ff;
      last_repeat_in = last_repeat_ff;
      head_in        = head_ff;
      fill_in        = fill_ff;
      head_ext       = EXT_W'(head_ff);
      fill_ext       = FEXT_W'(fill_ff);

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (advance) begin
         s1_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         if (is_record) begin
            last_source_in = new_entry.source;
            last_code_in   = new_entry.code;
            last_time_in   = new_entry.time_ms;
            last_repeat_in = new_entry.repeat_count;
            head_in = (head_ff == RING_AW'(RING_DEPTH - 1)) ? '0 : head_ff + 1'b1;
            if (fill_ff < FILL_W'(RING_DEPTH)) begin
               fill_in = fill_ff + 1'b1;
            end
            fill_ext = FEXT_W'(fill_in);
            rsp_in.out_source   = new_entry.source;
            rsp_in.out_code     = new_entry.code;
            rsp_in.out_time_ms  = new_entry.time_ms;
            rsp_in.repeat_count = new_entry.repeat_count;
            rsp_in.source_total = s1_src_ok_ff ? cnt_next : '0;
            rsp_in.recent_count = fill_ext[fldr_pkg::SLOT_W-1:0];
            rsp_in.slot_used    = head_ext[fldr_pkg::SLOT_W-1:0];
         end else begin
            rsp_in.out_source   = s1_slot_ok_ff ? ring_rd_entry.source : '0;
            rsp_in.out_code     = s1_slot_ok_ff ? ring_rd_entry.code : '0;
            rsp_in.out_time_ms  = s1_slot_ok_ff ? ring_rd_entry.time_ms : '0;
            rsp_in.repeat_count = s1_slot_ok_ff ? ring_rd_entry.repeat_count : '0;
            rsp_in.source_total = cnt_cur;
            rsp_in.recent_count = fill_ext[fldr_pkg::SLOT_W-1:0];
            rsp_in.slot_used    = s1_req_ff.read_slot;
         end
      end

      if (accept) begin
         s1_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_source_ff <= '0;
         last_code_ff   <= '0;
         last_time_ff   <= '0;
         last_repeat_ff <= '0;
         head_ff        <= '0;
         fill_ff        <= '0;
      end else begin
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_source_ff <= last_source_in;
         last_code_ff   <= last_code_in;
         last_time_ff   <= last_time_in;
         last_repeat_ff <= last_repeat_in;
         head_ff        <= head_in;
         fill_ff        <= fill_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (accept) begin
         s1_req_ff     <= req_data;
         s1_src_ok_ff  <= src_ok;
         s1_slot_ok_ff <= slot_ok;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

@@ tb/sv/fault_log_dedup_ring_test.sv @@
// Self-checking testbench of the fault log: folds faults in a predictor and checks every result.
`timescale 1ns / 1ps
module fault_log_dedup_ring_test;

   localparam int RING_SLOTS    = 12;
   localparam int RANDOM_ITEMS  = 130;
   localparam int NUM_PHASES    = 5;
   localparam int REPEAT_RUN    = 24;
   localparam int JAM_CYCLES    = 80;
   localparam int DRAIN_CYCLES  = 8;
   localparam int WATCHDOG_IDLE = 2000;

   logic              clock;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   fldr_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   fldr_pkg::rsp_type rsp_data;

   fault_log_dedup_ring #(
      .RING_DEPTH(RING_SLOTS)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // predictor state
   logic [fldr_pkg::TOTAL_W-1:0] src_totals [fldr_pkg::NUM_SOURCES];
   fldr_pkg::entry_type          last_fault;
   fldr_pkg::entry_type          ring_copy [RING_SLOTS];
   logic [fldr_pkg::SLOT_W-1:0]  ring_head;
   logic [fldr_pkg::SLOT_W-1:0]  ring_fill;

   fldr_pkg::req_type fault_stimulus [$];
   fldr_pkg::rsp_type expected_log_beats [$];
   fldr_pkg::rsp_type want;

   int failures        = 0;
   int results_checked = 0;
   int records_sent    = 0;
   int reads_sent      = 0;
   int send_idle_pct   = 0;
   int stall_pct       = 0;
   int jam_left        = 0;
   int quiet_cycles    = 0;
   logic jam_go        = 1'b0;
   logic jam_ack       = 1'b0;
   logic [fldr_pkg::SRC_W-1:0]  gen_src  = '0;
   logic [fldr_pkg::CODE_W-1:0] gen_code = '0;

   initial begin
      for (int i = 0; i < fldr_pkg::NUM_SOURCES; i++) src_totals[i] = '0;
      for (int i = 0; i < RING_SLOTS; i++) ring_copy[i] = '0;
      last_fault = '0;
      ring_head  = '0;
      ring_fill  = '0;
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic fldr_pkg::rsp_type fold_fault(input fldr_pkg::req_type r);
      fldr_pkg::rsp_type           res;
      fldr_pkg::entry_type         ent;
      logic [fldr_pkg::SLOT_W-1:0] slot;
      ent = '0;
      if (r.kind == fldr_pkg::KIND_READ) begin
         if (r.read_slot < RING_SLOTS) ent = ring_copy[r.read_slot];
         slot = r.read_slot;
      end else begin
         if (r.fault_source < fldr_pkg::SRC_LIMIT) src_totals[r.fault_source] += 1;
         if (last_fault.source == r.fault_source && last_fault.code == r.fault_code) begin
            if (last_fault.repeat_count != fldr_pkg::REPEAT_MAX)
               last_fault.repeat_count += 1;
         end else begin
            last_fault.source       = r.fault_source;
            last_fault.code         = r.fault_code;
            last_fault.repeat_count = fldr_pkg::REPEAT_ONE;
         end
         last_fault.time_ms = r.time_ms;
         ent  = last_fault;
         slot = ring_head;
         ring_copy[slot] = ent;
         ring_head = (slot == RING_SLOTS - 1) ? '0 : slot + 1'b1;
         if (ring_fill < RING_SLOTS) ring_fill += 1;
      end
      res.out_source   = ent.source;
      res.out_code     = ent.code;
      res.out_time_ms  = ent.time_ms;
      res.repeat_count = ent.repeat_count;
      res.source_total = (r.fault_source < fldr_pkg::SRC_LIMIT) ?
                         src_totals[r.fault_source] : '0;
      res.recent_count = ring_fill;
      res.slot_used    = slot;
      return res;
   endfunction

   function automatic fldr_pkg::req_type make_item(input logic kind,
                                                   input logic [fldr_pkg::SRC_W-1:0] src,
                                                   input logic [fldr_pkg::CODE_W-1:0] code,
                                                   input logic [fldr_pkg::TIME_W-1:0] stamp,
                                                   input logic [fldr_pkg::SLOT_W-1:0] slot);
      fldr_pkg::req_type r;
      r.kind         = kind;
      r.fault_source = src;
      r.fault_code   = code;
      r.time_ms      = stamp;
      r.read_slot    = slot;
      return r;
   endfunction

   // mostly real sources, with runs of the same fault so that repeats fold
   function automatic fldr_pkg::req_type random_item();
      fldr_pkg::req_type r;
      r.kind         = ($urandom_range(99) < 30) ? fldr_pkg::KIND_READ : fldr_pkg::KIND_RECORD;
      r.time_ms      = $urandom();
      r.read_slot    = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 12)) :
                                                  4'($urandom_range(11, 0));
      r.fault_code   = 4'($urandom_range(15));
      r.fault_source = ($urandom_range(9) == 0) ? 3'($urandom_range(7, 5)) :
                                                  3'($urandom_range(4, 0));
      if (r.kind == fldr_pkg::KIND_RECORD) begin
         if ($urandom_range(99) < 45) begin
            r.fault_source = gen_src;
            r.fault_code   = gen_code;
         end
         gen_src  = r.fault_source;
         gen_code = r.fault_code;
      end
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_val,
                              input logic [31:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected %0d, got %0d", name, exp_val, act_val);
         failures++;
      end
   endtask

   task automatic wait_sent();
      while (fault_stimulus.size() != 0 || req_valid) @(posedge clock);
   endtask

   // driver: hold a stalled beat, otherwise offer the next one unless idling
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_log_beats.push_back(fold_fault(req_data));
            if (req_data.kind == fldr_pkg::KIND_READ) reads_sent++;
            else records_sent++;
         end
         if (req_valid && req_stall) begin
         end else if (fault_stimulus.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_data  <= fault_stimulus.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         jam_left  <= 0;
         jam_ack   <= 1'b0;
      end else if (jam_go != jam_ack) begin
         jam_ack   <= jam_go;
         jam_left  <= JAM_CYCLES;
         rsp_stall <= 1'b1;
      end else if (jam_left != 0) begin
         jam_left  <= jam_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_log_beats.size() == 0) begin
            $error("result beat with no expectation waiting");
            failures++;
         end else begin
            want = expected_log_beats.pop_front();
            check_field("out_source", 32'(want.out_source), 32'(rsp_data.out_source));
            check_field("out_code", 32'(want.out_code), 32'(rsp_data.out_code));
            check_field("out_time_ms", want.out_time_ms, rsp_data.out_time_ms);
            check_field("repeat_count", 32'(want.repeat_count),
                        32'(rsp_data.repeat_count));
            check_field("source_total", want.source_total, rsp_data.source_total);
            check_field("recent_count", 32'(want.recent_count),
                        32'(rsp_data.recent_count));
            check_field("slot_used", 32'(want.slot_used), 32'(rsp_data.slot_used));
            results_checked++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_IDLE) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_send [NUM_PHASES];
      int phase_stall [NUM_PHASES];
      phase_send  = '{0, 80, 0, 38, 0};
      phase_stall = '{0, 0, 80, 38, 0};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // the fault left over from reset is source 0 code 0, so this one folds
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_RECORD, 3'd0, 4'd0, 32'd0, 4'd15));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_READ, 3'd0, 4'd0, 32'd0, 4'd0));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_READ, 3'd4, 4'd15, 32'hFFFF_FFFF,
                                         4'd11));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_READ, 3'd1, 4'd3, 32'd7, 4'd15));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_READ, 3'd2, 4'd5, 32'd9, 4'd12));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_RECORD, 3'd4, 4'd15, 32'hFFFF_FFFF,
                                         4'd0));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_RECORD, 3'd4, 4'd15, 32'd1, 4'd7));
      // sources without a counter still fold into the ring
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_RECORD, 3'd7, 4'd9, 32'h8000_0000,
                                         4'd3));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_RECORD, 3'd5, 4'd9, 32'h7FFF_FFFF,
                                         4'd8));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_READ, 3'd6, 4'd9, 32'd0, 4'd3));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_RECORD, 3'd1, 4'd0, 32'h5555_5555,
                                         4'd10));
      // run the head past the end of the ring
      for (int i = 0; i < 10; i++)
         fault_stimulus.push_back(make_item(fldr_pkg::KIND_RECORD, 3'(i % 5), 4'(i + 1),
                                            $urandom(), 4'(i)));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_READ, 3'd3, 4'd0, 32'd0, 4'd0));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_READ, 3'd2, 4'd0, 32'd0, 4'd11));
      // one fault repeated so that its count climbs
      for (int i = 0; i < REPEAT_RUN; i++)
         fault_stimulus.push_back(make_item(fldr_pkg::KIND_RECORD, 3'd3, 4'd15, $urandom(),
                                            4'($urandom_range(15))));
      fault_stimulus.push_back(make_item(fldr_pkg::KIND_READ, 3'd3, 4'd15, 32'd0, 4'd5));
      wait_sent();

      for (int p = 0; p < NUM_PHASES; p++) begin
         @(posedge clock);
         send_idle_pct <= phase_send[p];
         stall_pct     <= phase_stall[p];
         for (int i = 0; i < RANDOM_ITEMS; i++) fault_stimulus.push_back(random_item());
         // last phase: block the output so the input backs up
         if (p == NUM_PHASES - 1) jam_go <= ~jam_go;
         wait_sent();
      end

      while (expected_log_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Checked %0d results: %0d records, %0d reads.",
               results_checked, records_sent, reads_sent);
      $display("Covered ring wrap, repeat folding, unknown sources, out-of-range reads and a long output hold-off.");
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
